// ===== rtl/core/contact_impulse_resolver_macros.svh =====
// Assertion helpers for the contact impulse resolver.
`ifndef CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`ifndef SYNTH
`define CIR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define CIR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define CIR_ASSERT_IMP(label, clk, rst, ante, cons)
`define CIR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/cir_pkg.sv =====
package cir_pkg;
   localparam int VEL_W      = 32;
   localparam int NRM_W      = 16;
   localparam int MASS_W     = 32;
   localparam int BNC_W      = 15;
   localparam int NRM_FRAC   = 14;
   localparam int VEL_FRAC   = 16;
   localparam int SUM_W      = 51;
   localparam int ACC_W      = SUM_W - NRM_FRAC;
   localparam int F_W        = 16;
   localparam int J_W        = ACC_W + F_W - BNC_W;
   localparam int W_W        = VEL_FRAC + 1;
   localparam int G_W        = J_W;
   localparam int DLT_W      = G_W + NRM_W - NRM_FRAC;
   localparam int NEW_W      = DLT_W + 2;
   localparam int DEN_W      = MASS_W + 1;
   localparam int DIV_STAGES = W_W;

   localparam logic [BNC_W-1:0] BOUNCE_RST = BNC_W'(22938);
   localparam logic [W_W-1:0]   W_ONE      = W_W'(1) << VEL_FRAC;

   typedef enum logic {
      CSR_BOUNCE_A = 1'b0,
      CSR_BOUNCE_B = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][VEL_W-1:0] va;
      logic [2:0][VEL_W-1:0] vb;
      logic [2:0][NRM_W-1:0] nrm;
      logic                  sa;
      logic                  sb;
      logic                  app;
      logic [J_W-1:0]        j;
   } contact_type;

   function automatic logic [VEL_W-1:0] sat_vel(input logic [NEW_W-1:0] v);
      logic [VEL_W-1:0] r;
      if ((&v[NEW_W-1:VEL_W-1]) || !(|v[NEW_W-1:VEL_W-1])) begin
         r = v[VEL_W-1:0];
      end else if (v[NEW_W-1]) begin
         r = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(VEL_W-1){1'b1}}};
      end
      return r;
   endfunction
endpackage

// ===== rtl/core/cir_front.sv =====
module cir_front
   import cir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [2:0][VEL_W-1:0] va,
   input  logic [2:0][VEL_W-1:0] vb,
   input  logic [2:0][NRM_W-1:0] nrm,
   input  logic [MASS_W-1:0]     mass_a,
   input  logic [MASS_W-1:0]     mass_b,
   input  logic [1:0]            static_flags,
   input  logic [F_W-1:0]        f,
   output logic                  out_vld,
   output contact_type           out_ct,
   output logic [MASS_W-1:0]     out_mb,
   output logic [DEN_W-1:0]      out_den
);
   logic                      vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   contact_type               ct1_in, ct1_ff, ct2_ff, ct3_in, ct3_ff, ct4_in, ct4_ff;
   logic signed [VEL_W:0]     diff1_in [3];
   logic signed [VEL_W:0]     diff1_ff [3];
   logic signed [VEL_W+NRM_W:0] prod2_in [3];
   logic signed [VEL_W+NRM_W:0] prod2_ff [3];
   logic [MASS_W-1:0]         mb1_ff, mb2_ff, mb3_ff, mb4_ff;
   logic [DEN_W-1:0]          den1_in, den1_ff, den2_ff, den3_ff, den4_ff;
   logic signed [SUM_W-1:0]   neg_sum;
   logic [ACC_W-1:0]          a16_in, a16_ff;
   logic [ACC_W+F_W-1:0]      jprod;

   always_comb begin
      ct1_in     = '0;
      ct1_in.va  = va;
      ct1_in.vb  = vb;
      ct1_in.nrm = nrm;
      ct1_in.sa  = static_flags[0] || (mass_a == '0);
      ct1_in.sb  = static_flags[1] || (mass_b == '0);
      for (int i = 0; i < 3; i++) begin
         diff1_in[i] = $signed({vb[i][VEL_W-1], vb[i]}) - $signed({va[i][VEL_W-1], va[i]});
      end
      den1_in = {1'b0, mass_a} + {1'b0, mass_b};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod2_in[i] = diff1_ff[i] * $signed(ct1_ff.nrm[i]);
      end
   end

   // s < 0 is approach; keep the negated sum so a16 comes straight off it
   always_comb begin
      neg_sum = -(SUM_W'(prod2_ff[0]) + SUM_W'(prod2_ff[1]) + SUM_W'(prod2_ff[2]));
      a16_in  = neg_sum[SUM_W-1:NRM_FRAC];
      ct3_in  = ct2_ff;
      ct3_in.app = !neg_sum[SUM_W-1] && (|neg_sum) && !(ct2_ff.sa && ct2_ff.sb);
   end

   always_comb begin
      jprod    = a16_ff * f;
      ct4_in   = ct3_ff;
      ct4_in.j = jprod[ACC_W+F_W-1:BNC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
      ct1_ff  <= ct1_in;
      ct2_ff  <= ct1_ff;
      ct3_ff  <= ct3_in;
      ct4_ff  <= ct4_in;
      for (int i = 0; i < 3; i++) begin
         diff1_ff[i] <= diff1_in[i];
         prod2_ff[i] <= prod2_in[i];
      end
      a16_ff  <= a16_in;
      mb1_ff  <= mass_b;
      mb2_ff  <= mb1_ff;
      mb3_ff  <= mb2_ff;
      mb4_ff  <= mb3_ff;
      den1_ff <= den1_in;
      den2_ff <= den1_ff;
      den3_ff <= den2_ff;
      den4_ff <= den3_ff;
   end

   assign out_vld = vld4_ff;
   assign out_ct  = ct4_ff;
   assign out_mb  = mb4_ff;
   assign out_den = den4_ff;
endmodule

// ===== rtl/core/cir_div.sv =====
module cir_div
   import cir_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  contact_type       in_ct,
   input  logic [MASS_W-1:0] num,
   input  logic [DEN_W-1:0]  den,
   output logic              out_vld,
   output contact_type       out_ct,
   output logic [W_W-1:0]    quot,
   output logic              rem_nz
);
   // restoring divide of num * 2^16 by den, one quotient bit per stage
   logic [DIV_STAGES-1:0] vld_ff;
   contact_type           ct_ff  [DIV_STAGES];
   logic [DEN_W-1:0]      rem_ff [DIV_STAGES];
   logic [DEN_W-1:0]      den_ff [DIV_STAGES];
   logic [W_W-1:0]        q_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic             vld_prev;
      contact_type      ct_prev;
      logic [DEN_W-1:0] rem_prev, den_prev;
      logic [W_W-1:0]   q_prev;
      logic             bit_in;
      logic [DEN_W:0]   trial, sub;
      logic             ge;

      if (k == 0) begin : g_first
         assign vld_prev = in_vld;
         assign ct_prev  = in_ct;
         assign rem_prev = {2'b00, num[MASS_W-1:1]};
         assign den_prev = den;
         assign q_prev   = '0;
         assign bit_in   = num[0];
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign ct_prev  = ct_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign bit_in   = 1'b0;
      end

      assign trial = {rem_prev, bit_in};
      assign ge    = trial >= {1'b0, den_prev};
      assign sub   = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         ct_ff[k]  <= ct_prev;
         den_ff[k] <= den_prev;
         rem_ff[k] <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
         q_ff[k]   <= {q_prev[W_W-2:0], ge};
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   assign out_ct  = ct_ff[DIV_STAGES-1];
   assign quot    = q_ff[DIV_STAGES-1];
   assign rem_nz  = |rem_ff[DIV_STAGES-1];
endmodule

// ===== rtl/core/cir_back.sv =====
module cir_back
   import cir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  contact_type           in_ct,
   input  logic [W_W-1:0]        quot,
   input  logic                  rem_nz,
   output logic                  out_vld,
   output logic [2:0][VEL_W-1:0] new_a,
   output logic [2:0][VEL_W-1:0] new_b,
   output logic                  applied
);
   logic                  vld1_ff, vld2_ff, vld3_ff;
   contact_type           ct1_ff, ct2_ff;
   logic [W_W-1:0]        wa, wb;
   logic [J_W+W_W-1:0]    pa, pb;
   logic [G_W-1:0]        ga_ff, gb_ff;
   logic [NRM_W-1:0]      mag [3];
   logic [G_W+NRM_W-1:0]  qa [3];
   logic [G_W+NRM_W-1:0]  qb [3];
   logic [DLT_W-1:0]      da_ff [3];
   logic [DLT_W-1:0]      db_ff [3];
   logic [2:0][VEL_W-1:0] na_in, nb_in, na_ff, nb_ff;
   logic                  app_ff;
   logic signed [NEW_W-1:0] va_e, vb_e, da_e, db_e, sum_a, sum_b;

   // weights: the two floors add to 2^16, less one when the division is inexact
   always_comb begin
      priority if (in_ct.sa) begin
         wa = '0;
         wb = W_ONE;
      end else if (in_ct.sb) begin
         wa = W_ONE;
         wb = '0;
      end else begin
         wa = quot;
         wb = W_ONE - quot - W_W'(rem_nz);
      end
      pa = in_ct.j * wa;
      pb = in_ct.j * wb;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = ct1_ff.nrm[i][NRM_W-1] ? (~ct1_ff.nrm[i] + NRM_W'(1)) : ct1_ff.nrm[i];
         qa[i]  = ga_ff * mag[i];
         qb[i]  = gb_ff * mag[i];
      end
   end

   always_comb begin
      va_e  = '0;
      vb_e  = '0;
      da_e  = '0;
      db_e  = '0;
      sum_a = '0;
      sum_b = '0;
      for (int i = 0; i < 3; i++) begin
         va_e  = NEW_W'($signed(ct2_ff.va[i]));
         vb_e  = NEW_W'($signed(ct2_ff.vb[i]));
         da_e  = $signed({2'b00, da_ff[i]});
         db_e  = $signed({2'b00, db_ff[i]});
         sum_a = ct2_ff.nrm[i][NRM_W-1] ? (va_e + da_e) : (va_e - da_e);
         sum_b = ct2_ff.nrm[i][NRM_W-1] ? (vb_e - db_e) : (vb_e + db_e);
         na_in[i] = (ct2_ff.app && !ct2_ff.sa) ? sat_vel(sum_a) : ct2_ff.va[i];
         nb_in[i] = (ct2_ff.app && !ct2_ff.sb) ? sat_vel(sum_b) : ct2_ff.vb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      ct1_ff <= in_ct;
      ga_ff  <= pa[G_W+VEL_FRAC-1:VEL_FRAC];
      gb_ff  <= pb[G_W+VEL_FRAC-1:VEL_FRAC];
      ct2_ff <= ct1_ff;
      for (int i = 0; i < 3; i++) begin
         da_ff[i] <= qa[i][G_W+NRM_W-1:NRM_FRAC];
         db_ff[i] <= qb[i][G_W+NRM_W-1:NRM_FRAC];
      end
      na_ff  <= na_in;
      nb_ff  <= nb_in;
      // flag only rides with a valid transfer
      app_ff <= vld2_ff && ct2_ff.app;
   end

   assign out_vld = vld3_ff;
   assign new_a   = na_ff;
   assign new_b   = nb_ff;
   assign applied = app_ff;
endmodule

// ===== rtl/core/contact_impulse_resolver.sv =====
// Contact impulse resolver.
// Request: drive the contact on the req_ ports and pulse start; a contact is
// taken at every clock edge with start high and busy low. busy never rises,
// so one contact per cycle can stream in without gaps.
// Response: rsp_valid strobes for one cycle with the new velocities of both
// bodies and rsp_impulse_applied; the result must be taken in that cycle.
// From the accepting edge to the edge that takes the result, a contact passes
// 4 stages for the relative speed and impulse magnitude, 17 stages of the
// bit-per-stage mass-ratio divider and 3 stages for the weighted velocity
// deltas and saturation. Throughput is one contact per cycle; results leave
// in request order.
// CSR: csr_wr_en with csr_index 0 writes bounce_a, 1 writes bounce_b
// (Q0.15). Write only while no contact is in flight.
// Reset clears the pipeline valid bits and sets both bounce values to 0.7;
// a contact resolves fully only once it is out of reset.
`include "contact_impulse_resolver_macros.svh"
module contact_impulse_resolver
   import cir_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [VEL_W-1:0]  req_vel_a_x,
   input  logic [VEL_W-1:0]  req_vel_a_y,
   input  logic [VEL_W-1:0]  req_vel_a_z,
   input  logic [VEL_W-1:0]  req_vel_b_x,
   input  logic [VEL_W-1:0]  req_vel_b_y,
   input  logic [VEL_W-1:0]  req_vel_b_z,
   input  logic [NRM_W-1:0]  req_norm_x,
   input  logic [NRM_W-1:0]  req_norm_y,
   input  logic [NRM_W-1:0]  req_norm_z,
   input  logic [MASS_W-1:0] req_mass_a,
   input  logic [MASS_W-1:0] req_mass_b,
   input  logic [1:0]        req_static_flags,
   output logic              rsp_valid,
   output logic [VEL_W-1:0]  rsp_new_a_x,
   output logic [VEL_W-1:0]  rsp_new_a_y,
   output logic [VEL_W-1:0]  rsp_new_a_z,
   output logic [VEL_W-1:0]  rsp_new_b_x,
   output logic [VEL_W-1:0]  rsp_new_b_y,
   output logic [VEL_W-1:0]  rsp_new_b_z,
   output logic              rsp_impulse_applied,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [BNC_W-1:0]  csr_wdata
);
   logic [BNC_W-1:0]      bounce_a_ff, bounce_b_ff;
   logic [2*BNC_W-1:0]    eprod;
   logic [F_W-1:0]        f_in, f_ff;
   logic                  front_vld, div_vld;
   contact_type           front_ct, div_ct;
   logic [MASS_W-1:0]     front_mb;
   logic [DEN_W-1:0]      front_den;
   logic [W_W-1:0]        div_q;
   logic                  div_rem_nz;
   logic [2:0][VEL_W-1:0] new_a, new_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         bounce_a_ff <= BOUNCE_RST;
         bounce_b_ff <= BOUNCE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BOUNCE_A: bounce_a_ff <= csr_wdata;
            CSR_BOUNCE_B: bounce_b_ff <= csr_wdata;
         endcase
      end
      f_ff <= f_in;
   end

   // (1 + e) in Q1.15: e < 1, so adding 2^30 only sets the top bit
   assign eprod = bounce_a_ff * bounce_b_ff;
   assign f_in  = {1'b1, eprod[2*BNC_W-1:BNC_W]};

   assign busy = 1'b0;

   cir_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (start && !busy),
      .va           ({req_vel_a_z, req_vel_a_y, req_vel_a_x}),
      .vb           ({req_vel_b_z, req_vel_b_y, req_vel_b_x}),
      .nrm          ({req_norm_z, req_norm_y, req_norm_x}),
      .mass_a       (req_mass_a),
      .mass_b       (req_mass_b),
      .static_flags (req_static_flags),
      .f            (f_ff),
      .out_vld      (front_vld),
      .out_ct       (front_ct),
      .out_mb       (front_mb),
      .out_den      (front_den)
   );

   cir_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (front_vld),
      .in_ct   (front_ct),
      .num     (front_mb),
      .den     (front_den),
      .out_vld (div_vld),
      .out_ct  (div_ct),
      .quot    (div_q),
      .rem_nz  (div_rem_nz)
   );

   cir_back u_back (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (div_vld),
      .in_ct   (div_ct),
      .quot    (div_q),
      .rem_nz  (div_rem_nz),
      .out_vld (rsp_valid),
      .new_a   (new_a),
      .new_b   (new_b),
      .applied (rsp_impulse_applied)
   );

   assign rsp_new_a_x = new_a[0];
   assign rsp_new_a_y = new_a[1];
   assign rsp_new_a_z = new_a[2];
   assign rsp_new_b_x = new_b[0];
   assign rsp_new_b_y = new_b[1];
   assign rsp_new_b_z = new_b[2];

   `CIR_ASSERT_IMP(a_applied_only_valid, clock, reset, rsp_impulse_applied, rsp_valid)
   `CIR_ASSERT_IMP(a_no_impulse_both_static, clock, reset, front_vld && front_ct.app, !(front_ct.sa && front_ct.sb))
   `CIR_ASSERT_IMP(a_weight_in_range, clock, reset, div_vld && !div_ct.sa && !div_ct.sb, div_q <= W_ONE)
   `CIR_ASSERT_NXT(a_bounce_a_write, clock, reset, csr_wr_en && (csr_index == CSR_BOUNCE_A), bounce_a_ff == $past(csr_wdata))
endmodule

// ===== test/tb.sv =====
module tb;
   import cir_pkg::*;

   typedef struct {
      logic signed [VEL_W-1:0] va[3];
      logic signed [VEL_W-1:0] vb[3];
      logic signed [NRM_W-1:0] nrm[3];
      logic [MASS_W-1:0]       mass_a;
      logic [MASS_W-1:0]       mass_b;
      logic [1:0]              flags;
   } contact_rec_type;

   typedef struct {
      logic [VEL_W-1:0] a[3];
      logic [VEL_W-1:0] b[3];
      logic             applied;
   } outcome_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [VEL_W-1:0]  req_vel_a_x, req_vel_a_y, req_vel_a_z;
   logic [VEL_W-1:0]  req_vel_b_x, req_vel_b_y, req_vel_b_z;
   logic [NRM_W-1:0]  req_norm_x, req_norm_y, req_norm_z;
   logic [MASS_W-1:0] req_mass_a, req_mass_b;
   logic [1:0]        req_static_flags;
   logic              rsp_valid;
   logic [VEL_W-1:0]  rsp_new_a_x, rsp_new_a_y, rsp_new_a_z;
   logic [VEL_W-1:0]  rsp_new_b_x, rsp_new_b_y, rsp_new_b_z;
   logic              rsp_impulse_applied;
   logic              csr_wr_en;
   csr_idx_type       csr_index;
   logic [BNC_W-1:0]  csr_wdata;

   logic [BNC_W-1:0]  bounce_a_cfg;
   logic [BNC_W-1:0]  bounce_b_cfg;
   outcome_type       pending_velocities[$];
   int                mismatch_count;
   int                stall_cycles;

   contact_impulse_resolver u_top (
      .clock, .reset, .start, .busy,
      .req_vel_a_x, .req_vel_a_y, .req_vel_a_z,
      .req_vel_b_x, .req_vel_b_y, .req_vel_b_z,
      .req_norm_x, .req_norm_y, .req_norm_z,
      .req_mass_a, .req_mass_b, .req_static_flags,
      .rsp_valid,
      .rsp_new_a_x, .rsp_new_a_y, .rsp_new_a_z,
      .rsp_new_b_x, .rsp_new_b_y, .rsp_new_b_z,
      .rsp_impulse_applied,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [VEL_W-1:0] clamp_velocity(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VEL_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[VEL_W-1:0];
   endfunction

   function automatic outcome_type resolve_contact(contact_rec_type c);
      longint     va[3];
      longint     vb[3];
      longint     nr[3];
      longint     spd;
      longint     da;
      longint     db;
      logic [63:0] ma, mb, a16, f, j, wa, wb, ga, gb, mag, ba, bb;
      bit         sa, sb;
      outcome_type r;
      ma  = 64'(c.mass_a);
      mb  = 64'(c.mass_b);
      ba  = 64'(bounce_a_cfg);
      bb  = 64'(bounce_b_cfg);
      sa  = c.flags[0] || (ma == 0);
      sb  = c.flags[1] || (mb == 0);
      spd = 0;
      for (int i = 0; i < 3; i++) begin
         va[i] = longint'(c.va[i]);
         vb[i] = longint'(c.vb[i]);
         nr[i] = longint'(c.nrm[i]);
         spd += (vb[i] - va[i]) * nr[i];
         r.a[i] = c.va[i];
         r.b[i] = c.vb[i];
      end
      r.applied = 1'b0;
      if (spd < 0 && !(sa && sb)) begin
         a16 = 64'(-spd) >> NRM_FRAC;
         f   = ((64'd1 << 30) + ba * bb) >> BNC_W;
         j   = (a16 * f) >> BNC_W;
         if (sa) begin
            wa = 0;
            wb = 64'd65536;
         end else if (sb) begin
            wa = 64'd65536;
            wb = 0;
         end else begin
            wa = (mb << 16) / (ma + mb);
            wb = (ma << 16) / (ma + mb);
         end
         ga = (j * wa) >> 16;
         gb = (j * wb) >> 16;
         for (int i = 0; i < 3; i++) begin
            mag = (nr[i] < 0) ? 64'(-nr[i]) : 64'(nr[i]);
            da  = longint'((ga * mag) >> NRM_FRAC);
            db  = longint'((gb * mag) >> NRM_FRAC);
            if (nr[i] < 0) begin
               da = -da;
               db = -db;
            end
            if (!sa) r.a[i] = clamp_velocity(va[i] - da);
            if (!sb) r.b[i] = clamp_velocity(vb[i] + db);
         end
         r.applied = 1'b1;
      end
      return r;
   endfunction

   function automatic contact_rec_type make_contact(longint ax, longint ay, longint az,
                                                    longint bx, longint by, longint bz,
                                                    int nx, int ny, int nz,
                                                    longint ma,
                                                    longint mb,
                                                    logic [1:0] fl);
      contact_rec_type c;
      c.va[0] = ax[VEL_W-1:0];
      c.va[1] = ay[VEL_W-1:0];
      c.va[2] = az[VEL_W-1:0];
      c.vb[0] = bx[VEL_W-1:0];
      c.vb[1] = by[VEL_W-1:0];
      c.vb[2] = bz[VEL_W-1:0];
      c.nrm[0] = nx[NRM_W-1:0];
      c.nrm[1] = ny[NRM_W-1:0];
      c.nrm[2] = nz[NRM_W-1:0];
      c.mass_a = ma[MASS_W-1:0];
      c.mass_b = mb[MASS_W-1:0];
      c.flags  = fl;
      return c;
   endfunction

   function automatic logic [31:0] random_velocity();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
      endcase
   endfunction

   function automatic logic [31:0] random_mass();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 100 << 16);
      endcase
   endfunction

   function automatic contact_rec_type random_contact();
      contact_rec_type c;
      for (int i = 0; i < 3; i++) begin
         c.va[i] = random_velocity();
         c.vb[i] = random_velocity();
         case ($urandom_range(0, 4))
            0:       c.nrm[i] = 16'($urandom);
            1:       c.nrm[i] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: c.nrm[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
         endcase
      end
      c.mass_a = random_mass();
      c.mass_b = random_mass();
      // mostly dynamic pairs so the division path gets the bulk of the traffic
      c.flags  = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00;
      return c;
   endfunction

   task automatic send_contact(contact_rec_type c);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_vel_a_x      <= c.va[0];
      req_vel_a_y      <= c.va[1];
      req_vel_a_z      <= c.va[2];
      req_vel_b_x      <= c.vb[0];
      req_vel_b_y      <= c.vb[1];
      req_vel_b_z      <= c.vb[2];
      req_norm_x       <= c.nrm[0];
      req_norm_y       <= c.nrm[1];
      req_norm_z       <= c.nrm[2];
      req_mass_a       <= c.mass_a;
      req_mass_b       <= c.mass_b;
      req_static_flags <= c.flags;
      do @(negedge clock); while (busy);
      @(posedge clock);
      pending_velocities.push_back(resolve_contact(c));
   endtask

   task automatic set_bounce(logic [BNC_W-1:0] ba, logic [BNC_W-1:0] bb);
      start <= 1'b0;
      @(posedge clock);
      wait (pending_velocities.size() == 0);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BOUNCE_A;
      csr_wdata <= ba;
      @(posedge clock);
      csr_index <= CSR_BOUNCE_B;
      csr_wdata <= bb;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      bounce_a_cfg  = ba;
      bounce_b_cfg  = bb;
   endtask

   task automatic test_directed();
      longint one;
      one = 64'sd1 <<< 16;
      // separating along the normal, both dynamic, equal masses
      send_contact(make_contact(one, 0, 0, -one, 0, 0, -16384, 0, 0, one, one, 2'b00));
      // approaching along the normal
      send_contact(make_contact(-one, 0, 0, one, 0, 0, -16384, 0, 0, one, one, 2'b00));
      // zero relative speed
      send_contact(make_contact(one, one, 0, one, one, 0, 0, 16384, 0, one, one, 2'b00));
      // each static combination
      send_contact(make_contact(0, one, 0, 0, -one, 0, 0, -16384, 0, one, one, 2'b01));
      send_contact(make_contact(0, one, 0, 0, -one, 0, 0, -16384, 0, one, one, 2'b10));
      send_contact(make_contact(0, one, 0, 0, -one, 0, 0, -16384, 0, one, one, 2'b11));
      // zero masses count as static
      send_contact(make_contact(0, 0, one, 0, 0, -one, 0, 0, -16384, 0, one, 2'b00));
      send_contact(make_contact(0, 0, one, 0, 0, -one, 0, 0, -16384, one, 0, 2'b00));
      send_contact(make_contact(0, 0, one, 0, 0, -one, 0, 0, -16384, 0, 0, 2'b00));
      // extreme masses
      send_contact(make_contact(5 * one, 0, 0, -5 * one, 0, 0, -16384, 0, 0,
                                32'hFFFF_FFFF, 32'd1, 2'b00));
      send_contact(make_contact(5 * one, 0, 0, -5 * one, 0, 0, -16384, 0, 0,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00));
      // velocity extremes, both separating along the normal
      send_contact(make_contact(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                                -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                                -16384, -16384, -16384, one, one, 2'b00));
      send_contact(make_contact(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                                64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                                16384, 16384, 16384, one, one, 2'b00));
      // out-of-range normal component
      send_contact(make_contact(64'sh7FFF_FFFF, 0, 0, -64'sh8000_0000, 0, 0,
                                -32768, 32767, -1, 32'd1, 32'd1, 2'b00));
      send_contact(make_contact(-one, 3 * one, 0, 2 * one, -one, one,
                                11585, -11585, 0, 2 * one, 3 * one, 2'b00));
   endtask

   task automatic test_random(int count);
      repeat (count) send_contact(random_contact());
   endtask

   task automatic test_bounce_settings();
      set_bounce('1, '1);
      test_random(200);
      set_bounce('0, '0);
      test_random(150);
      set_bounce('1, '0);
      test_random(100);
      set_bounce(BNC_W'($urandom), BNC_W'($urandom));
      test_random(200);
      set_bounce(BOUNCE_RST, BOUNCE_RST);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(negedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_velocities.size() == 0) begin
            report("unexpected transfer", 32'(rsp_valid), 32'd0);
         end else begin
            want = pending_velocities.pop_front();
            if (rsp_new_a_x !== want.a[0]) report("new_a_x", rsp_new_a_x, want.a[0]);
            if (rsp_new_a_y !== want.a[1]) report("new_a_y", rsp_new_a_y, want.a[1]);
            if (rsp_new_a_z !== want.a[2]) report("new_a_z", rsp_new_a_z, want.a[2]);
            if (rsp_new_b_x !== want.b[0]) report("new_b_x", rsp_new_b_x, want.b[0]);
            if (rsp_new_b_y !== want.b[1]) report("new_b_y", rsp_new_b_y, want.b[1]);
            if (rsp_new_b_z !== want.b[2]) report("new_b_z", rsp_new_b_z, want.b[2]);
            if (rsp_impulse_applied !== want.applied)
               report("impulse_applied", 32'(rsp_impulse_applied), 32'(want.applied));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= 2000) begin
         $display("contact_impulse_resolver: mismatch");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_BOUNCE_A;
      csr_wdata        = '0;
      req_vel_a_x      = '0;
      req_vel_a_y      = '0;
      req_vel_a_z      = '0;
      req_vel_b_x      = '0;
      req_vel_b_y      = '0;
      req_vel_b_z      = '0;
      req_norm_x       = '0;
      req_norm_y       = '0;
      req_norm_z       = '0;
      req_mass_a       = '0;
      req_mass_b       = '0;
      req_static_flags = '0;
      bounce_a_cfg     = BOUNCE_RST;
      bounce_b_cfg     = BOUNCE_RST;
      mismatch_count   = 0;
      stall_cycles     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(220);
      test_bounce_settings();
      test_directed();
      start <= 1'b0;
      wait (pending_velocities.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("contact_impulse_resolver: match");
      end else begin
         $display("contact_impulse_resolver: mismatch");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cir_pkg.sv
rtl/core/cir_front.sv
rtl/core/cir_div.sv
rtl/core/cir_back.sv
rtl/core/contact_impulse_resolver.sv
test/tb.sv
